FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the presence list RTL.
// Concurrent checks compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// prop must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
// expr must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

FILE: hw/rtl/opl_pkg.sv
// Package for the ordered presence list: widths, request and command codes,
// engine states and the command / result structs. No dependencies.
package opl_pkg;

  localparam int unsigned LIST_CAP_DEF  = 16;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;
  localparam int unsigned ID_W          = 16;
  localparam int unsigned REQ_W         = 2;
  localparam int unsigned OUT_CNT_W     = 5;

  // Request codes on the input channel
  localparam logic [REQ_W-1:0] REQ_ARRIVE  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REBUILD = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR   = 2'd2;

  typedef enum logic [1:0] {
    OP_ARRIVE,
    OP_REBUILD,
    OP_CLEAR,
    OP_NOP
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_APPEND,
    ST_STREAM
  } state_e;

  typedef struct packed {
    op_e             op;
    logic [ID_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic [ID_W-1:0]      entry_index;
    logic                 entry_valid;
    logic [OUT_CNT_W-1:0] present_count;
    logic                 last;
    logic                 overflow;
  } rsp_t;

endpackage

FILE: hw/rtl/opl_chan_if.sv
// Channel interfaces of the presence list: request in, result out.
// Valid/ready handshake; uses opl_pkg for field widths.
interface opl_req_if;
  logic                        valid;
  logic                        ready;
  logic [opl_pkg::REQ_W-1:0]   req_type;
  logic [opl_pkg::ID_W-1:0]    robot_id;

  modport source (output valid, output req_type, output robot_id, input ready);
  modport sink   (input valid, input req_type, input robot_id, output ready);
endinterface

interface opl_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [opl_pkg::ID_W-1:0]        entry_index;
  logic                            entry_valid;
  logic [opl_pkg::OUT_CNT_W-1:0]   present_count;
  logic                            last;
  logic                            overflow;

  modport source (output valid, output entry_index, output entry_valid,
                  output present_count, output last, output overflow, input ready);
  modport sink   (input valid, input entry_index, input entry_valid,
                  input present_count, input last, input overflow, output ready);
endinterface

FILE: hw/rtl/opl_front.sv
// Front end: holds the id offset register, accepts requests and turns
// them into engine commands. Uses opl_pkg and opl_req_if.
module opl_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [opl_pkg::ID_W-1:0] cfg_wdata_i,
  opl_req_if.sink                 req_i,
  input  logic                    full_i,
  output logic                    push_o,
  output opl_pkg::cmd_t           cmd_o
);
  import opl_pkg::*;

  logic [ID_W-1:0] offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
    end else if (cfg_we_i) begin
      offset_q <= cfg_wdata_i;
    end
  end

  assign req_i.ready = !full_i;
  assign push_o      = req_i.valid && !full_i;

  always_comb begin
    cmd_o.idx = req_i.robot_id - offset_q;  // wraps mod 2^16
    unique case (req_i.req_type)
      REQ_ARRIVE:  cmd_o.op = OP_ARRIVE;
      REQ_REBUILD: cmd_o.op = OP_REBUILD;
      REQ_CLEAR:   cmd_o.op = OP_CLEAR;
      default:     cmd_o.op = OP_NOP;
    endcase
  end

endmodule

FILE: hw/rtl/opl_queue.sv
// Short command queue between front end and engine.
// Uses opl_pkg for the command type.
`include "assert_macros.svh"
module opl_queue #(
  parameter int unsigned DEPTH = opl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  opl_pkg::cmd_t cmd_i,
  output logic          full_o,
  output logic          cmd_valid_o,
  output opl_pkg::cmd_t cmd_o,
  input  logic          pop_i
);
  import opl_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);

  cmd_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o      = (cnt_q == DEPTH_C);
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  `ASSERT_CLK(a_q_cnt_range, clk_i, rst_ni, cnt_q <= DEPTH_C)
  `ASSERT_NEVER(a_q_pop_empty, clk_i, rst_ni, pop_i && (cnt_q == '0))
  `ASSERT_CLK(a_q_push_fill, clk_i, rst_ni, (push_i && !pop_i) |=> (cnt_q != '0))

endmodule

FILE: hw/rtl/opl_engine.sv
// Back end: owns the pending, current and rebuild lists, executes commands
// and drives the result register. Uses opl_pkg and opl_rsp_if.
`include "assert_macros.svh"
module opl_engine #(
  parameter int unsigned LIST_CAPACITY = opl_pkg::LIST_CAP_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  opl_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  opl_rsp_if.source     rsp_o
);
  import opl_pkg::*;

  localparam int unsigned IDX_W = $clog2(LIST_CAPACITY);
  localparam int unsigned CNT_W = $clog2(LIST_CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(LIST_CAPACITY);

  state_e state_q, state_d;

  logic [ID_W-1:0] cur_q   [LIST_CAPACITY];
  logic [ID_W-1:0] pend_q  [LIST_CAPACITY];
  logic [ID_W-1:0] fresh_q [LIST_CAPACITY];

  logic [CNT_W-1:0] cur_cnt_q, cur_cnt_d;
  logic [CNT_W-1:0] pend_cnt_q, pend_cnt_d;
  logic [CNT_W-1:0] scan_q, scan_d;       // walk index for all phases
  logic [CNT_W-1:0] n_q, n_d;             // rebuild list length
  logic [LIST_CAPACITY-1:0] taken_q, taken_d;

  logic rsp_valid_q, rsp_valid_d;
  rsp_t rsp_q, rsp_d;
  logic rsp_load;
  logic out_free;

  // list write ports
  logic            pend_we, cur_we, fresh_we;
  logic [ID_W-1:0] fresh_wdata;

  logic [LIST_CAPACITY-1:0] pend_mask;
  logic [LIST_CAPACITY-1:0] arr_vec;
  logic [LIST_CAPACITY-1:0] match_vec;
  logic [ID_W-1:0]          cur_rd, pend_rd, fresh_rd;
  logic                     arr_hit, pend_full;
  logic [IDX_W-1:0]         scan_idx;

  assign scan_idx  = scan_q[IDX_W-1:0];
  assign cur_rd    = cur_q[scan_idx];
  assign pend_rd   = pend_q[scan_idx];
  assign fresh_rd  = fresh_q[scan_idx];
  assign pend_full = (pend_cnt_q == CAP_C);
  assign out_free  = !rsp_valid_q || rsp_o.ready;

  // parallel compare against the live pending entries
  always_comb begin
    for (int j = 0; j < LIST_CAPACITY; j++) begin
      pend_mask[j] = (CNT_W'(j) < pend_cnt_q);
      arr_vec[j]   = pend_mask[j] && (pend_q[j] == cmd_i.idx);
      match_vec[j] = pend_mask[j] && !taken_q[j] && (pend_q[j] == cur_rd);
    end
  end
  assign arr_hit = |arr_vec;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && (cmd_i.op == OP_REBUILD)) state_d = ST_MATCH;
      end
      ST_MATCH: begin
        if (scan_q == cur_cnt_q) state_d = ST_APPEND;
      end
      ST_APPEND: begin
        if (scan_q == pend_cnt_q) state_d = ST_STREAM;
      end
      ST_STREAM: begin
        if (out_free && ((n_q == '0) || (scan_q == n_q - CNT_W'(1)))) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cur_cnt_d   = cur_cnt_q;
    pend_cnt_d  = pend_cnt_q;
    scan_d      = scan_q;
    n_d         = n_q;
    taken_d     = taken_q;
    cmd_pop_o   = 1'b0;
    pend_we     = 1'b0;
    cur_we      = 1'b0;
    fresh_we    = 1'b0;
    fresh_wdata = cur_rd;
    rsp_load    = 1'b0;
    rsp_d       = rsp_q;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            OP_REBUILD: begin
              cmd_pop_o = 1'b1;
              scan_d    = '0;
              n_d       = '0;
              taken_d   = '0;
            end
            OP_ARRIVE: begin
              if (out_free) begin
                cmd_pop_o           = 1'b1;
                rsp_load            = 1'b1;
                rsp_d.entry_index   = '0;
                rsp_d.entry_valid   = 1'b0;
                rsp_d.present_count = OUT_CNT_W'(cur_cnt_q);
                rsp_d.last          = 1'b1;
                rsp_d.overflow      = !arr_hit && pend_full;
                if (!arr_hit && !pend_full) begin
                  pend_we    = 1'b1;
                  pend_cnt_d = pend_cnt_q + CNT_W'(1);
                end
              end
            end
            OP_CLEAR: begin
              if (out_free) begin
                cmd_pop_o           = 1'b1;
                cur_cnt_d           = '0;
                pend_cnt_d          = '0;
                rsp_load            = 1'b1;
                rsp_d.entry_index   = '0;
                rsp_d.entry_valid   = 1'b0;
                rsp_d.present_count = '0;
                rsp_d.last          = 1'b1;
                rsp_d.overflow      = 1'b0;
              end
            end
            default: begin
              if (out_free) begin
                cmd_pop_o           = 1'b1;
                rsp_load            = 1'b1;
                rsp_d.entry_index   = '0;
                rsp_d.entry_valid   = 1'b0;
                rsp_d.present_count = OUT_CNT_W'(cur_cnt_q);
                rsp_d.last          = 1'b1;
                rsp_d.overflow      = 1'b0;
              end
            end
          endcase
        end
      end
      // keep old members that are still pending, in old order
      ST_MATCH: begin
        if (scan_q != cur_cnt_q) begin
          scan_d = scan_q + CNT_W'(1);
          if (|match_vec) begin
            taken_d     = taken_q | match_vec;
            fresh_we    = 1'b1;
            fresh_wdata = cur_rd;
            n_d         = n_q + CNT_W'(1);
          end
        end else begin
          scan_d = '0;
        end
      end
      // then newcomers in arrival order
      ST_APPEND: begin
        if (scan_q != pend_cnt_q) begin
          scan_d = scan_q + CNT_W'(1);
          if (!taken_q[scan_idx]) begin
            fresh_we    = 1'b1;
            fresh_wdata = pend_rd;
            n_d         = n_q + CNT_W'(1);
          end
        end else begin
          scan_d     = '0;
          cur_cnt_d  = n_q;
          pend_cnt_d = '0;
          taken_d    = '0;  // pending list empties, so no entry stays taken
        end
      end
      // stream the new list, committing it to the current list as it goes
      ST_STREAM: begin
        if (out_free) begin
          rsp_load            = 1'b1;
          rsp_d.overflow      = 1'b0;
          rsp_d.present_count = OUT_CNT_W'(n_q);
          if (n_q == '0) begin
            rsp_d.entry_index = '0;
            rsp_d.entry_valid = 1'b0;
            rsp_d.last        = 1'b1;
          end else begin
            rsp_d.entry_index = fresh_rd;
            rsp_d.entry_valid = 1'b1;
            rsp_d.last        = (scan_q == n_q - CNT_W'(1));
            cur_we            = 1'b1;
            scan_d            = scan_q + CNT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign rsp_valid_d = rsp_load ? 1'b1 : (rsp_o.ready ? 1'b0 : rsp_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cur_cnt_q   <= '0;
      pend_cnt_q  <= '0;
      scan_q      <= '0;
      n_q         <= '0;
      taken_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_cnt_q   <= cur_cnt_d;
      pend_cnt_q  <= pend_cnt_d;
      scan_q      <= scan_d;
      n_q         <= n_d;
      taken_q     <= taken_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_load) rsp_q <= rsp_d;
    if (pend_we)  pend_q[pend_cnt_q[IDX_W-1:0]] <= cmd_i.idx;
    if (fresh_we) fresh_q[n_q[IDX_W-1:0]] <= fresh_wdata;
    if (cur_we)   cur_q[scan_idx] <= fresh_rd;
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.entry_index   = rsp_q.entry_index;
  assign rsp_o.entry_valid   = rsp_q.entry_valid;
  assign rsp_o.present_count = rsp_q.present_count;
  assign rsp_o.last          = rsp_q.last;
  assign rsp_o.overflow      = rsp_q.overflow;

  `ASSERT_CLK(a_pend_cnt_range, clk_i, rst_ni, pend_cnt_q <= CAP_C)
  `ASSERT_CLK(a_cur_cnt_range, clk_i, rst_ni, cur_cnt_q <= CAP_C)
  `ASSERT_CLK(a_n_le_pend, clk_i, rst_ni, (state_q == ST_APPEND) |-> (n_q <= pend_cnt_q))
  `ASSERT_NEVER(a_taken_live, clk_i, rst_ni, (taken_q & ~pend_mask) != '0)
  `ASSERT_CLK(a_stream_idx, clk_i, rst_ni,
              ((state_q == ST_STREAM) && (n_q != '0)) |-> (scan_q < n_q))
  `ASSERT_NEVER(a_no_load_stall, clk_i, rst_ni, rsp_load && !out_free)

endmodule

FILE: hw/rtl/ordered_presence_list.sv
// Ordered presence list: keeps the ordered list of agents present at a site.
// Request channel req_i: req_type 0 = arrival of robot_id, 1 = end-of-tick
// rebuild, 2 = clear both lists, 3 = no-op. Result channel rsp_o.
// An arrival stores robot_id minus the id offset in the pending list unless
// already pending; a full pending list drops it and flags overflow. It gives
// one result. A rebuild keeps old members still pending in their old order,
// appends newcomers in arrival order, empties the pending list and streams
// the new list, one result per entry (last on the final one); an empty list
// gives a single result with entry_valid low. Clear and no-op give one result.
// Config: cfg_we_i/cfg_wdata_i write the id offset; write only while idle.
// Flow: an accepted command is written into the QUEUE_DEPTH-entry queue
// (two entries by default) before the engine sees it; arrival, clear and
// no-op results leave through the engine's result register. A rebuild
// walks the current list, then the pending list, and then streams the new
// list; the engine runs one command at a time, so later ones wait queued.
// Reset clears both counts, the offset and all handshake state; list
// contents need no reset. When the receiver holds rsp_o.ready low, the
// result register holds, the engine waits and the queue fills, after which
// req_i.ready drops.
module ordered_presence_list #(
  parameter int unsigned LIST_CAPACITY = opl_pkg::LIST_CAP_DEF,
  parameter int unsigned QUEUE_DEPTH   = opl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [opl_pkg::ID_W-1:0] cfg_wdata_i,
  opl_req_if.sink                  req_i,
  opl_rsp_if.source                rsp_o
);
  import opl_pkg::*;

  // front -> queue
  logic push;
  logic q_full;
  cmd_t front_cmd;

  // queue -> engine
  logic cmd_valid;
  logic cmd_pop;
  cmd_t eng_cmd;

  opl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .full_i      (q_full),
    .push_o      (push),
    .cmd_o       (front_cmd)
  );

  opl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .cmd_i       (front_cmd),
    .full_o      (q_full),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (eng_cmd),
    .pop_i       (cmd_pop)
  );

  opl_engine #(
    .LIST_CAPACITY (LIST_CAPACITY)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (eng_cmd),
    .cmd_pop_o   (cmd_pop),
    .rsp_o       (rsp_o)
  );

endmodule
